// File: rtl/core/lss_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ---------------------------------------------------------------------------
// lss_pkg
// shared types, widths and codes of the latency sample statistics block
// ---------------------------------------------------------------------------
package lss_pkg;

  localparam int unsigned SampleDepth = 1024;
  localparam int unsigned SampleBits  = 32;
  localparam int unsigned CntW        = $clog2(SampleDepth + 1);
  localparam int unsigned IdxW        = $clog2(SampleDepth);
  localparam int unsigned SumW        = SampleBits + IdxW;
  localparam int unsigned AccW        = 2 * SumW + IdxW;
  localparam int unsigned FracShift   = 16;
  localparam int unsigned DivNW       = AccW + FracShift;
  localparam int unsigned DivDW       = 3 * IdxW + 3;
  localparam int unsigned RootW       = SampleBits + 9;
  localparam int unsigned SqrtOpW     = 2 * RootW;
  localparam int unsigned FxW         = 40;
  localparam int unsigned HalfW       = SumW / 2;
  localparam int unsigned PreW        = 17;
  localparam int unsigned RecipMul    = 167773;
  localparam int unsigned RecipShift  = 24;
  localparam int unsigned RecipW      = 18;
  localparam int unsigned ProdW       = PreW + RecipW;

  localparam logic [1:0] CMD_ADD    = 2'd0;
  localparam logic [1:0] CMD_REMOVE = 2'd1;
  localparam logic [1:0] CMD_REPORT = 2'd2;

  localparam logic [1:0] STAT_OK        = 2'd0;
  localparam logic [1:0] STAT_NOT_FOUND = 2'd1;
  localparam logic [1:0] STAT_FULL      = 2'd2;
  localparam logic [1:0] STAT_EMPTY     = 2'd3;

  typedef enum logic [1:0] {
    CH_HOLD,
    CH_INSERT,
    CH_REMOVE,
    CH_ROTATE
  } chain_op_e;

  typedef struct packed {
    chain_op_e               op;
    logic [SampleBits-1:0]   smp;
  } chain_ctrl_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_EXEC,
    S_PASS1,
    S_PASS2,
    S_DIV_MEAN,
    S_DIV_DEV,
    S_SQRT,
    S_RESP
  } state_e;

  typedef struct packed {
    logic [1:0]  cmd;
    logic [31:0] sample;
  } in_t;

  typedef struct packed {
    logic [1:0]  status;
    logic [10:0] count;
    logic [31:0] minimum;
    logic [31:0] maximum;
    logic [39:0] mean_fx;
    logic [31:0] median;
    logic [31:0] pct90;
    logic [31:0] pct95;
    logic [31:0] pct99;
    logic [39:0] stddev_fx;
  } out_t;

endpackage
`default_nettype wire

// File: rtl/core/lss_cell.sv
`timescale 1ns / 1ps
`default_nettype none
// ---------------------------------------------------------------------------
// lss_cell
// one slot of the sorted sample chain: insert, remove shift and rotate
// ---------------------------------------------------------------------------
module lss_cell (
  input  wire logic                          clk_i,
  input  wire lss_pkg::chain_ctrl_t          ctrl_i,
  input  wire logic                          occ_i,
  input  wire logic                          at_end_i,
  input  wire logic                          left_gt_i,
  input  wire logic [lss_pkg::SampleBits-1:0] left_i,
  input  wire logic [lss_pkg::SampleBits-1:0] right_i,
  output logic [lss_pkg::SampleBits-1:0]      val_o,
  output logic                               gt_o,
  output logic                               ge_o,
  output logic                               eq_o
);
  import lss_pkg::*;

  logic [SampleBits-1:0] val_q, val_d;

  assign val_o = val_q;
  assign gt_o  = occ_i && (val_q > ctrl_i.smp);
  assign ge_o  = occ_i && (val_q >= ctrl_i.smp);
  assign eq_o  = occ_i && (val_q == ctrl_i.smp);

  always_comb begin
    val_d = val_q;
    case (ctrl_i.op)
      CH_INSERT: begin
        if (left_gt_i) begin
          val_d = left_i;
        end else if (gt_o || at_end_i) begin
          val_d = ctrl_i.smp;
        end
      end
      CH_REMOVE: begin
        if (ge_o) begin
          val_d = right_i;
        end
      end
      CH_ROTATE: val_d = right_i;
      default:   val_d = val_q;
    endcase
  end

  always_ff @(posedge clk_i) begin
    val_q <= val_d;
  end

endmodule
`default_nettype wire

// File: rtl/core/lss_div.sv
`timescale 1ns / 1ps
`default_nettype none
// ---------------------------------------------------------------------------
// lss_div
// restoring divider, one quotient bit per cycle
// ---------------------------------------------------------------------------
module lss_div (
  input  wire logic                      clk_i,
  input  wire logic                      rst_ni,
  input  wire logic                      start_i,
  input  wire logic [lss_pkg::DivNW-1:0] num_i,
  input  wire logic [lss_pkg::DivDW-1:0] den_i,
  output logic                           done_o,
  output logic [lss_pkg::DivNW-1:0]      quot_o
);
  import lss_pkg::*;

  localparam int unsigned StepW = $clog2(DivNW + 1);

  logic [DivNW-1:0] quo_q;
  logic [DivDW:0]   rem_q;
  logic [DivDW-1:0] den_q;
  logic [StepW-1:0] step_q;
  logic             busy_q;
  logic             done_q;
  logic [DivDW:0]   rem_sh;
  logic             take;

  assign rem_sh = {rem_q[DivDW-1:0], quo_q[DivNW-1]};
  assign take   = rem_sh >= {1'b0, den_q};
  assign done_o = done_q;
  assign quot_o = quo_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      step_q <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        step_q <= StepW'(DivNW);
      end else if (busy_q) begin
        step_q <= step_q - 1'b1;
        if (step_q == StepW'(1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      quo_q <= num_i;
      rem_q <= '0;
      den_q <= den_i;
    end else if (busy_q) begin
      rem_q <= take ? (rem_sh - {1'b0, den_q}) : rem_sh;
      quo_q <= {quo_q[DivNW-2:0], take};
    end
  end

endmodule
`default_nettype wire

// File: rtl/core/lss_sqrt.sv
`timescale 1ns / 1ps
`default_nettype none
// ---------------------------------------------------------------------------
// lss_sqrt
// digit by digit integer square root, one root bit per cycle
// ---------------------------------------------------------------------------
module lss_sqrt (
  input  wire logic                        clk_i,
  input  wire logic                        rst_ni,
  input  wire logic                        start_i,
  input  wire logic [lss_pkg::SqrtOpW-1:0] op_i,
  output logic                             done_o,
  output logic [lss_pkg::RootW-1:0]        root_o
);
  import lss_pkg::*;

  localparam int unsigned RemW  = RootW + 3;
  localparam int unsigned StepW = $clog2(RootW + 1);

  logic [SqrtOpW-1:0] op_q;
  logic [RemW-1:0]    rem_q;
  logic [RootW-1:0]   root_q;
  logic [StepW-1:0]   step_q;
  logic               busy_q;
  logic               done_q;
  logic [RemW-1:0]    rem_sh;
  logic [RemW-1:0]    trial;
  logic               take;

  assign rem_sh = {rem_q[RemW-3:0], op_q[SqrtOpW-1 -: 2]};
  assign trial  = {1'b0, root_q, 2'b01};
  assign take   = rem_sh >= trial;
  assign done_o = done_q;
  assign root_o = root_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      step_q <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        step_q <= StepW'(RootW);
      end else if (busy_q) begin
        step_q <= step_q - 1'b1;
        if (step_q == StepW'(1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      op_q   <= op_i;
      rem_q  <= '0;
      root_q <= '0;
    end else if (busy_q) begin
      op_q   <= {op_q[SqrtOpW-3:0], 2'b00};
      rem_q  <= take ? (rem_sh - trial) : rem_sh;
      root_q <= {root_q[RootW-2:0], take};
    end
  end

endmodule
`default_nettype wire

// File: rtl/core/latency_sample_statistics.sv
`timescale 1ns / 1ps
`default_nettype none
// ---------------------------------------------------------------------------
// latency_sample_statistics
// sorted sample store in a ring of cells with count, min, max, mean,
// median, percentiles and standard deviation reports
// ---------------------------------------------------------------------------
// add, remove and unused commands: the state passes through S_EXEC and S_RESP,
// and the whole cell chain inserts or shifts at once in S_EXEC
// report: two full rotations of the 1024 cell ring, then a divide for the
// mean, a divide for the deviation and a square root
// one transaction at a time; a finished result waits in the output register
// reset clears the count and control; cell contents are not reset
// ---------------------------------------------------------------------------
module latency_sample_statistics (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          in_valid_i,
  output logic               in_stall_o,
  input  wire lss_pkg::in_t  in_data_i,
  output logic               out_valid_o,
  input  wire logic          out_stall_i,
  output lss_pkg::out_t      out_data_o
);
  import lss_pkg::*;

  state_e              state_q, state_d;
  logic [CntW-1:0]     cnt_q;
  logic [1:0]          cmd_q;
  logic [SampleBits-1:0] smp_q;
  logic [CntW-1:0]     k_q;
  logic [SumW-1:0]     sum_q;
  logic [2*CntW-1:0]   n2_q;
  logic [DivDW-1:0]    n3_q;
  logic [PreW-1:0]     pre90_q, pre95_q, pre99_q;
  logic [IdxW-1:0]     pos_med_q, pos90_q, pos95_q, pos99_q;
  logic                va_q, vb_q, vc_q;
  logic [SumW-1:0]     t_q, d_q;
  logic [SumW-1:0]     hh_q, hl_q, ll_q;
  logic [AccW-1:0]     acc_q;
  out_t                res_q, out_q;
  out_t                exec_res;
  logic                out_valid_q;

  chain_ctrl_t         ctrl;
  logic [SampleBits-1:0] val [SampleDepth];
  logic [SampleDepth-1:0] gt, ge, eq;
  logic                found;
  logic [SampleBits-1:0] head;
  logic                in_ok;

  logic                div_start, div_done;
  logic [DivNW-1:0]    div_num;
  logic [DivDW-1:0]    div_den;
  logic [DivNW-1:0]    quot;
  logic                sq_start, sq_done;
  logic [RootW-1:0]    root;
  logic                pass2_end;
  logic                resp_go;

  assign head      = val[0];
  assign found     = |eq;
  assign in_ok     = (state_q == S_IDLE) && in_valid_i;
  assign in_stall_o = (state_q != S_IDLE);
  assign pass2_end = (state_q == S_PASS2) && (k_q == CntW'(SampleDepth + 3));
  assign resp_go   = (state_q == S_RESP) && (!out_valid_q || !out_stall_i);
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  for (genvar i = 0; i < SampleDepth; i++) begin : g_cell
    logic [SampleBits-1:0] left_v;
    logic                  left_g;
    if (i == 0) begin : g_first
      assign left_v = '0;
      assign left_g = 1'b0;
    end else begin : g_rest
      assign left_v = val[i-1];
      assign left_g = gt[i-1];
    end
    lss_cell u_cell (
      .clk_i     (clk_i),
      .ctrl_i    (ctrl),
      .occ_i     (cnt_q > CntW'(i)),
      .at_end_i  (cnt_q == CntW'(i)),
      .left_gt_i (left_g),
      .left_i    (left_v),
      .right_i   (val[(i + 1) % SampleDepth]),
      .val_o     (val[i]),
      .gt_o      (gt[i]),
      .ge_o      (ge[i]),
      .eq_o      (eq[i])
    );
  end

  assign div_num = (state_q == S_PASS2) ?
                   {{(DivNW - SumW - 8){1'b0}}, sum_q, 8'd0} :
                   {acc_q, {FracShift{1'b0}}};
  assign div_den = (state_q == S_PASS2) ? {{(DivDW - CntW){1'b0}}, cnt_q} : n3_q;

  lss_div u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (div_start),
    .num_i   (div_num),
    .den_i   (div_den),
    .done_o  (div_done),
    .quot_o  (quot)
  );

  lss_sqrt u_sqrt (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (sq_start),
    .op_i    (quot[SqrtOpW-1:0]),
    .done_o  (sq_done),
    .root_o  (root)
  );

  always_comb begin
    state_d   = state_q;
    ctrl.op   = CH_HOLD;
    ctrl.smp  = smp_q;
    div_start = 1'b0;
    sq_start  = 1'b0;
    unique case (state_q)
      S_IDLE: begin
        if (in_ok) begin
          state_d = S_EXEC;
        end
      end
      S_EXEC: begin
        state_d = S_RESP;
        if (cmd_q == CMD_ADD) begin
          if (cnt_q < CntW'(SampleDepth)) begin
            ctrl.op = CH_INSERT;
          end
        end else if (cmd_q == CMD_REMOVE) begin
          if (found) begin
            ctrl.op = CH_REMOVE;
          end
        end else if (cmd_q == CMD_REPORT) begin
          if (cnt_q != '0) begin
            state_d = S_PASS1;
          end
        end
      end
      S_PASS1: begin
        ctrl.op = CH_ROTATE;
        if (k_q == CntW'(SampleDepth - 1)) begin
          state_d = S_PASS2;
        end
      end
      S_PASS2: begin
        if (k_q < CntW'(SampleDepth)) begin
          ctrl.op = CH_ROTATE;
        end
        if (pass2_end) begin
          div_start = 1'b1;
          state_d   = S_DIV_MEAN;
        end
      end
      S_DIV_MEAN: begin
        if (div_done) begin
          div_start = 1'b1;
          state_d   = S_DIV_DEV;
        end
      end
      S_DIV_DEV: begin
        if (div_done) begin
          sq_start = 1'b1;
          state_d  = S_SQRT;
        end
      end
      S_SQRT: begin
        if (sq_done) begin
          state_d = S_RESP;
        end
      end
      S_RESP: begin
        if (resp_go) begin
          state_d = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  // status and count of the transaction in execution
  always_comb begin
    exec_res       = '0;
    exec_res.count = cnt_q;
    if (cmd_q == CMD_ADD) begin
      if (cnt_q < CntW'(SampleDepth)) begin
        exec_res.count = cnt_q + 1'b1;
      end else begin
        exec_res.status = STAT_FULL;
      end
    end else if (cmd_q == CMD_REMOVE) begin
      if (found) begin
        exec_res.count = cnt_q - 1'b1;
      end else begin
        exec_res.status = STAT_NOT_FOUND;
      end
    end else if (cmd_q == CMD_REPORT) begin
      if (cnt_q == '0) begin
        exec_res.status = STAT_EMPTY;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      cnt_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (state_q == S_EXEC) begin
        if (ctrl.op == CH_INSERT) begin
          cnt_q <= cnt_q + 1'b1;
        end else if (ctrl.op == CH_REMOVE) begin
          cnt_q <= cnt_q - 1'b1;
        end
      end
      if (resp_go) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // datapath
  always_ff @(posedge clk_i) begin
    if (in_ok) begin
      cmd_q <= in_data_i.cmd;
      smp_q <= in_data_i.sample;
    end
    if (resp_go) begin
      out_q <= res_q;
    end
    case (state_q)
      S_EXEC: begin
        res_q   <= exec_res;
        k_q     <= '0;
        sum_q   <= '0;
        acc_q   <= '0;
        va_q    <= 1'b0;
        vb_q    <= 1'b0;
        vc_q    <= 1'b0;
        n2_q    <= cnt_q * cnt_q;
        pre90_q <= PreW'(cnt_q) * PreW'(90) + PreW'(50);
        pre95_q <= PreW'(cnt_q) * PreW'(95) + PreW'(50);
        pre99_q <= PreW'(cnt_q) * PreW'(99) + PreW'(50);
        pos_med_q <= IdxW'(((cnt_q + 1'b1) >> 1) - 1'b1);
      end
      S_PASS1: begin
        n3_q    <= DivDW'(n2_q) * DivDW'(cnt_q);
        pos90_q <= IdxW'(((ProdW'(pre90_q) * ProdW'(RecipMul)) >> RecipShift) - 1'b1);
        pos95_q <= IdxW'(((ProdW'(pre95_q) * ProdW'(RecipMul)) >> RecipShift) - 1'b1);
        pos99_q <= IdxW'(((ProdW'(pre99_q) * ProdW'(RecipMul)) >> RecipShift) - 1'b1);
        if (k_q < cnt_q) begin
          sum_q <= sum_q + SumW'(head);
        end
        k_q <= (k_q == CntW'(SampleDepth - 1)) ? '0 : k_q + 1'b1;
      end
      S_PASS2: begin
        k_q  <= k_q + 1'b1;
        va_q <= (k_q < cnt_q);
        t_q  <= SumW'(cnt_q) * SumW'(head);
        vb_q <= va_q;
        d_q  <= (t_q >= sum_q) ? (t_q - sum_q) : (sum_q - t_q);
        vc_q <= vb_q;
        hh_q <= d_q[SumW-1:HalfW] * d_q[SumW-1:HalfW];
        hl_q <= d_q[SumW-1:HalfW] * d_q[HalfW-1:0];
        ll_q <= d_q[HalfW-1:0] * d_q[HalfW-1:0];
        if (vc_q) begin
          acc_q <= acc_q + (AccW'(hh_q) << (2 * HalfW)) + (AccW'(hl_q) << (HalfW + 1))
                   + AccW'(ll_q);
        end
        if (k_q < cnt_q) begin
          if (k_q == '0) begin
            res_q.minimum <= head;
          end
          if (k_q == cnt_q - 1'b1) begin
            res_q.maximum <= head;
          end
          if (k_q[IdxW-1:0] == pos_med_q) begin
            res_q.median <= head;
          end
          if (k_q[IdxW-1:0] == pos90_q) begin
            res_q.pct90 <= head;
          end
          if (k_q[IdxW-1:0] == pos95_q) begin
            res_q.pct95 <= head;
          end
          if (k_q[IdxW-1:0] == pos99_q) begin
            res_q.pct99 <= head;
          end
        end
      end
      S_DIV_MEAN: begin
        if (div_done) begin
          res_q.mean_fx <= quot[FxW-1:0];
        end
      end
      S_SQRT: begin
        if (sq_done) begin
          res_q.stddev_fx <= root[FxW-1:0];
        end
      end
      default: begin
      end
    endcase
  end

endmodule
`default_nettype wire

// File: tb/testbench.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// testbench
// checks latency_sample_statistics against a sorted-queue predictor: adds,
// removes, reports, unused commands, empty store, random traffic
// under sender and receiver idling
// ---------------------------------------------------------------------------
module testbench;
  import lss_pkg::*;

  localparam logic [1:0] CMD_UNUSED = 2'd3;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic in_valid_i = 1'b0;
  logic in_stall_o;
  in_t in_data_i = '0;
  logic out_valid_o;
  logic out_stall_i = 1'b0;
  out_t out_data_o;

  int send_idle_pct = 0;
  int recv_stall_pct = 0;
  int error_count = 0;
  bit [31:0] held_samples[$];
  out_t pending_results[$];

  latency_sample_statistics dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .in_data_i  (in_data_i),
    .out_valid_o(out_valid_o),
    .out_stall_i(out_stall_i),
    .out_data_o (out_data_o)
  );

  always #4 clk_i = ~clk_i;

  always @(negedge clk_i) begin
    out_stall_i <= ($urandom_range(99) < recv_stall_pct);
  end

  function automatic bit [31:0] rank_pick(int n, int p);
    int idx;
    idx = (p * n + 50) / 100;
    if (idx < 1) idx = 1;
    if (idx > n) idx = n;
    return held_samples[idx - 1];
  endfunction

  // updates the held samples and returns the result of one transaction
  function automatic out_t predict_stats(in_t t);
    out_t r;
    int n;
    int pos;
    bit [63:0] sum;
    bit [63:0] prod;
    bit [63:0] diff;
    bit [127:0] dev;
    bit [127:0] cand;
    bit [40:0] root;
    r = '0;
    n = held_samples.size();
    case (t.cmd)
      CMD_ADD: begin
        if (n >= SampleDepth) begin
          r.status = STAT_FULL;
        end else begin
          pos = n;
          while (pos > 0 && held_samples[pos - 1] > t.sample) pos--;
          held_samples.insert(pos, t.sample);
        end
      end
      CMD_REMOVE: begin
        pos = -1;
        for (int i = 0; i < n; i++) begin
          if (pos < 0 && held_samples[i] == t.sample) pos = i;
        end
        if (pos >= 0) held_samples.delete(pos);
        else r.status = STAT_NOT_FOUND;
      end
      CMD_REPORT: begin
        if (n == 0) begin
          r.status = STAT_EMPTY;
        end else begin
          sum = 0;
          foreach (held_samples[i]) sum += held_samples[i];
          dev = 0;
          foreach (held_samples[i]) begin
            prod = 64'(n) * held_samples[i];
            diff = (prod >= sum) ? prod - sum : sum - prod;
            dev += 128'(diff) * 128'(diff);
          end
          dev = dev * 65536;
          dev = dev / n / n / n;
          root = 0;
          for (int b = 40; b >= 0; b--) begin
            cand = 128'(root | (41'd1 << b));
            if (cand * cand <= dev) root = cand[40:0];
          end
          r.minimum = held_samples[0];
          r.maximum = held_samples[n - 1];
          r.mean_fx = 40'((sum / n) * 256 + ((sum % n) * 256) / n);
          r.median = held_samples[(n + 1) / 2 - 1];
          r.pct90 = rank_pick(n, 90);
          r.pct95 = rank_pick(n, 95);
          r.pct99 = rank_pick(n, 99);
          r.stddev_fx = root[39:0];
        end
      end
      default: ;
    endcase
    r.count = 11'(held_samples.size());
    return r;
  endfunction

  task automatic report_mismatch(string what, logic [39:0] got, logic [39:0] want);
    error_count++;
    $display("mismatch %s: got %0h expected %0h at %0t", what, got, want, $time);
  endtask

  always @(posedge clk_i) begin
    out_t want;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (pending_results.size() == 0) begin
        report_mismatch("unexpected result", 40'(out_data_o.status), 0);
      end else begin
        want = pending_results.pop_front();
        if (out_data_o.status !== want.status)
          report_mismatch("status", out_data_o.status, want.status);
        if (out_data_o.count !== want.count)
          report_mismatch("count", out_data_o.count, want.count);
        if (out_data_o.minimum !== want.minimum)
          report_mismatch("minimum", out_data_o.minimum, want.minimum);
        if (out_data_o.maximum !== want.maximum)
          report_mismatch("maximum", out_data_o.maximum, want.maximum);
        if (out_data_o.mean_fx !== want.mean_fx)
          report_mismatch("mean_fx", out_data_o.mean_fx, want.mean_fx);
        if (out_data_o.median !== want.median)
          report_mismatch("median", out_data_o.median, want.median);
        if (out_data_o.pct90 !== want.pct90)
          report_mismatch("pct90", out_data_o.pct90, want.pct90);
        if (out_data_o.pct95 !== want.pct95)
          report_mismatch("pct95", out_data_o.pct95, want.pct95);
        if (out_data_o.pct99 !== want.pct99)
          report_mismatch("pct99", out_data_o.pct99, want.pct99);
        if (out_data_o.stddev_fx !== want.stddev_fx)
          report_mismatch("stddev_fx", out_data_o.stddev_fx, want.stddev_fx);
      end
    end
  end

  // entered and left at a falling edge
  task automatic send_item(logic [1:0] cmd, logic [31:0] smp);
    in_t t;
    t.cmd = cmd;
    t.sample = smp;
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid_i <= 1'b0;
      @(negedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_data_i <= t;
    do @(posedge clk_i); while (in_stall_o);
    pending_results.push_back(predict_stats(t));
    @(negedge clk_i);
  endtask

  task automatic drain_results();
    in_valid_i <= 1'b0;
    while (pending_results.size() != 0) @(negedge clk_i);
    repeat (20) @(negedge clk_i);
  endtask

  task automatic test_directed();
    send_item(CMD_REPORT, 32'h0);
    send_item(CMD_REMOVE, 32'h5);
    send_item(CMD_UNUSED, 32'hFFFF_FFFF);
    send_item(CMD_ADD, 32'h0);
    send_item(CMD_REPORT, 32'h0);
    send_item(CMD_ADD, 32'hFFFF_FFFF);
    send_item(CMD_REPORT, 32'h0);
    send_item(CMD_REMOVE, 32'h5);
    send_item(CMD_ADD, 32'h7);
    send_item(CMD_ADD, 32'h3);
    send_item(CMD_ADD, 32'h7);
    send_item(CMD_ADD, 32'hAAAA_AAAA);
    send_item(CMD_ADD, 32'h5555_5555);
    send_item(CMD_ADD, 32'hFFFF_FFFF);
    send_item(CMD_REPORT, 32'h0);
    send_item(CMD_REMOVE, 32'h7);
    send_item(CMD_REMOVE, 32'hFFFF_FFFF);
    send_item(CMD_REPORT, 32'h0);
    send_item(CMD_UNUSED, 32'h1234_5678);
    while (held_samples.size() != 0) send_item(CMD_REMOVE, held_samples[0]);
    send_item(CMD_REPORT, 32'h0);
    drain_results();
  endtask

  function automatic logic [31:0] random_sample();
    case ($urandom_range(3))
      0: return $urandom;
      1: return $urandom_range(15);
      2: return 32'hFFFF_FFF0 | $urandom_range(15);
      default: return $urandom_range(1000);
    endcase
  endfunction

  task automatic test_random_traffic(int idle_pct, int stall_pct, int items);
    int roll;
    send_idle_pct = idle_pct;
    recv_stall_pct = stall_pct;
    for (int k = 0; k < items; k++) begin
      roll = $urandom_range(99);
      if (held_samples.size() > 48 && roll < 45) roll = 50;
      if (k == items / 2) drain_results();
      if (roll < 45) send_item(CMD_ADD, random_sample());
      else if (roll < 68 && held_samples.size() != 0)
        send_item(CMD_REMOVE, held_samples[$urandom_range(held_samples.size() - 1)]);
      else if (roll < 75) send_item(CMD_REMOVE, random_sample());
      else if (roll < 95) send_item(CMD_REPORT, $urandom);
      else send_item(CMD_UNUSED, $urandom);
    end
    drain_results();
  endtask

  initial begin
    repeat (11) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);
    test_directed();
    test_random_traffic(6, 52, 90);
    test_random_traffic(52, 6, 90);
    test_random_traffic(0, 0, 90);
    if (error_count == 0) begin
      $display("latency_sample_statistics regression: pass");
    end else begin
      $display("latency_sample_statistics regression: fail");
    end
    $finish;
  end

  initial begin
    #50ms;
    $display("latency_sample_statistics regression: fail");
    $finish;
  end

endmodule

// File: latency_sample_statistics.f
rtl/core/lss_pkg.sv
rtl/core/lss_cell.sv
rtl/core/lss_div.sv
rtl/core/lss_sqrt.sv
rtl/core/latency_sample_statistics.sv
tb/testbench.sv
